// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the files that check their own logic.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define STCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STCB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STCB_ASSERT(lbl, prop, msg)
`define STCB_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/stcb_pkg.sv =====
package stcb_pkg;

  localparam int LEVELS_DEF    = 8;
  localparam int MAX_CHARS_DEF = 6;
  localparam int GLYPH_COLS    = 5;
  localparam int SLOT_COLS     = 6;
  localparam int GLYPH_COUNT   = 36;
  // Wide enough for any buffer index over the supported parameter range.
  localparam int ADDR_W        = 8;

  localparam logic [15:0] PERIOD_RESET = 16'd500;
  localparam logic [5:0]  BLANK_GLYPH  = 6'd36;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_WINDOW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [5:0]        glyph;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_WINDOW
  } bk_state_t;

  // Five columns per glyph, letters A to Z first, then digits 0 to 9.
  localparam logic [7:0] FONT_COLS [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h1C, 8'h28, 8'h48, 8'h28, 8'h1C}, '{8'h7C, 8'h54, 8'h54, 8'h54, 8'h28},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h44}, '{8'h7C, 8'h44, 8'h44, 8'h44, 8'h38},
    '{8'h7C, 8'h54, 8'h54, 8'h44, 8'h44}, '{8'h7C, 8'h50, 8'h50, 8'h40, 8'h40},
    '{8'h38, 8'h44, 8'h44, 8'h54, 8'h5C}, '{8'h7C, 8'h10, 8'h10, 8'h10, 8'h7C},
    '{8'h44, 8'h44, 8'h7C, 8'h44, 8'h44}, '{8'h48, 8'h44, 8'h44, 8'h78, 8'h40},
    '{8'h7C, 8'h10, 8'h10, 8'h28, 8'h44}, '{8'h7C, 8'h04, 8'h04, 8'h04, 8'h04},
    '{8'h7C, 8'h20, 8'h10, 8'h20, 8'h7C}, '{8'h7C, 8'h20, 8'h10, 8'h08, 8'h7C},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38}, '{8'h7C, 8'h50, 8'h50, 8'h50, 8'h20},
    '{8'h38, 8'h44, 8'h54, 8'h48, 8'h34}, '{8'h7C, 8'h50, 8'h50, 8'h50, 8'h2C},
    '{8'h24, 8'h54, 8'h54, 8'h54, 8'h48}, '{8'h40, 8'h40, 8'h7C, 8'h40, 8'h40},
    '{8'h78, 8'h04, 8'h04, 8'h04, 8'h78}, '{8'h70, 8'h08, 8'h04, 8'h08, 8'h70},
    '{8'h7C, 8'h08, 8'h10, 8'h08, 8'h7C}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
    '{8'h40, 8'h20, 8'h1C, 8'h20, 8'h40}, '{8'h44, 8'h4C, 8'h54, 8'h64, 8'h44},
    '{8'h38, 8'h4C, 8'h54, 8'h64, 8'h38}, '{8'h00, 8'h44, 8'h7C, 8'h04, 8'h00},
    '{8'h4C, 8'h54, 8'h54, 8'h54, 8'h24}, '{8'h44, 8'h44, 8'h54, 8'h54, 8'h28},
    '{8'h18, 8'h28, 8'h48, 8'h7C, 8'h08}, '{8'h74, 8'h54, 8'h54, 8'h54, 8'h48},
    '{8'h38, 8'h54, 8'h54, 8'h54, 8'h48}, '{8'h40, 8'h44, 8'h48, 8'h50, 8'h60},
    '{8'h28, 8'h54, 8'h54, 8'h54, 8'h28}, '{8'h24, 8'h54, 8'h54, 8'h54, 8'h38}
  };

  // Maps an ASCII code to a glyph number; anything outside A-Z and 0-9 is blank.
  function automatic logic [5:0] glyph_of(input logic [7:0] code);
    logic [5:0] g;
    g = BLANK_GLYPH;
    if (code inside {[8'h41:8'h5A]}) begin
      g = 6'(code - 8'h41);
    end else if (code inside {[8'h30:8'h39]}) begin
      g = 6'(code - 8'h30) + 6'd26;
    end
    return g;
  endfunction

  // Column of a six-column slot: five glyph columns, then a blank spacer.
  function automatic logic [7:0] font_col(input logic [5:0] glyph, input logic [2:0] col);
    logic [7:0] v;
    v = 8'h00;
    if (glyph < BLANK_GLYPH && col < 3'(GLYPH_COLS)) begin
      v = FONT_COLS[glyph][col];
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/stcb_front.sv =====
module stcb_front import stcb_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int BUF_LEN = LEVELS + SLOT_COLS * MAX_CHARS;
  localparam int AW      = $clog2(BUF_LEN);
  localparam int CW      = $clog2(MAX_CHARS + 1);

  logic [15:0]   period_r;
  logic [15:0]   tick_r, tick_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] chars_r, chars_nxt;
  logic          accept;
  logic [15:0]   tick_inc;
  logic [AW-1:0] slot_base;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign tick_inc  = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
  assign slot_base = AW'(LEVELS) + AW'(chars_r) * AW'(SLOT_COLS);

  always_comb begin
    tick_nxt    = tick_r;
    pos_nxt     = pos_r;
    chars_nxt   = chars_r;
    q_push      = 1'b0;
    q_cmd.kind  = CMD_CLEAR;
    q_cmd.glyph = BLANK_GLYPH;
    q_cmd.addr  = '0;
    if (accept) begin
      case (op_t'(in_operation))
        OP_CLEAR: begin
          tick_nxt   = '0;
          pos_nxt    = '0;
          chars_nxt  = '0;
          q_push     = 1'b1;
          q_cmd.kind = CMD_CLEAR;
        end
        OP_LOAD: begin
          if (chars_r < CW'(MAX_CHARS)) begin
            chars_nxt   = chars_r + CW'(1);
            q_push      = 1'b1;
            q_cmd.kind  = CMD_LOAD;
            q_cmd.glyph = glyph_of(in_char_code);
            q_cmd.addr  = ADDR_W'(slot_base);
          end
        end
        OP_TICK: begin
          tick_nxt = tick_inc;
          if (period_r == 16'd0) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_WINDOW;
          end else if (tick_inc >= period_r) begin
            tick_nxt   = '0;
            q_push     = 1'b1;
            q_cmd.kind = CMD_WINDOW;
            q_cmd.addr = ADDR_W'(pos_r);
            pos_nxt    = (pos_r == AW'(BUF_LEN - 1)) ? '0 : pos_r + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      tick_r   <= '0;
      pos_r    <= '0;
      chars_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      tick_r  <= tick_nxt;
      pos_r   <= pos_nxt;
      chars_r <= chars_nxt;
    end
  end

endmodule

// ===== rtl/core/stcb_queue.sv =====
module stcb_queue import stcb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  input  logic pop,
  output cmd_t head
);

  // Two-entry command queue between the front and the back.
  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/stcb_back.sv =====
module stcb_back import stcb_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_level,
  output logic [7:0] out_pattern,
  output logic       out_last
);

  localparam int BUF_LEN = LEVELS + SLOT_COLS * MAX_CHARS;
  localparam int AW      = $clog2(BUF_LEN);
  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [7:0]         mem [BUF_LEN];
  logic [BUF_LEN-1:0] vld_r;

  bk_state_t     st_r, st_nxt;
  logic [AW-1:0] addr_r, addr_nxt, addr_inc;
  logic [2:0]    col_r, col_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [5:0]    glyph_r, glyph_nxt;

  logic          rd_v_r;
  logic [7:0]    rd_q_r;
  logic          rd_hit_r;
  logic [LW-1:0] rd_idx_r;

  logic          out_valid_r;
  logic [2:0]    out_level_r;
  logic [7:0]    out_pattern_r;
  logic          out_last_r;

  logic out_take, rd_move, issue, wr_en, clr;

  assign out_take = !out_valid_r || !out_stall;
  assign rd_move  = rd_v_r && out_take;
  assign addr_inc = (addr_r == AW'(BUF_LEN - 1)) ? '0 : addr_r + AW'(1);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            CMD_LOAD:   st_nxt = BK_LOAD;
            CMD_WINDOW: st_nxt = BK_WINDOW;
            default:    st_nxt = BK_IDLE;
          endcase
        end
      end
      BK_LOAD: begin
        if (col_r == 3'(SLOT_COLS - 1)) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_WINDOW: begin
        if (issue && idx_r == LW'(LEVELS - 1)) begin
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    addr_nxt  = addr_r;
    col_nxt   = col_r;
    idx_nxt   = idx_r;
    glyph_nxt = glyph_r;
    q_pop     = 1'b0;
    clr       = 1'b0;
    wr_en     = 1'b0;
    issue     = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          clr       = (q_head.kind == CMD_CLEAR);
          addr_nxt  = AW'(q_head.addr);
          col_nxt   = '0;
          idx_nxt   = '0;
          glyph_nxt = q_head.glyph;
        end
      end
      BK_LOAD: begin
        wr_en    = 1'b1;
        col_nxt  = col_r + 3'd1;
        addr_nxt = addr_r + AW'(1);
      end
      BK_WINDOW: begin
        if (!rd_v_r || out_take) begin
          issue    = 1'b1;
          idx_nxt  = idx_r + LW'(1);
          addr_nxt = addr_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      vld_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (issue) begin
        rd_v_r <= 1'b1;
      end else if (rd_move) begin
        rd_v_r <= 1'b0;
      end
      if (rd_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= font_col(glyph_r, col_r);
    end
    if (issue) begin
      rd_q_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    col_r   <= col_nxt;
    idx_r   <= idx_nxt;
    glyph_r <= glyph_nxt;
    if (issue) begin
      rd_hit_r <= vld_r[addr_r];
      rd_idx_r <= idx_r;
    end
    if (rd_move) begin
      out_level_r   <= 3'(rd_idx_r);
      out_pattern_r <= rd_hit_r ? rd_q_r : 8'h00;
      out_last_r    <= (rd_idx_r == LW'(LEVELS - 1));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_pattern = out_pattern_r;
  assign out_last    = out_last_r;

endmodule

// ===== rtl/core/scrolling_text_column_buffer_unit.sv =====
// A window's first column goes through the command queue, the back end's state
// register, the read stage and the output register after its tick item is taken.
// Through the back end's single memory port, a window streams LEVELS columns,
// one a cycle while out_stall is low, and a load writes its six columns, one a cycle.
// Reset (rst_n low at a clock edge) empties the buffer at once through per-column
// valid bits, zeroes the counters and sets the scroll period to 500 ticks.
`include "assert_macros.svh"

module scrolling_text_column_buffer_unit import stcb_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_level,
  output logic [7:0]  out_pattern,
  output logic        out_last
);

  // The front end takes items unless the queue is full, keeps the tick counter,
  // the scroll position, the character count and the scroll period, and turns
  // each item into at most one command: clear, load a glyph at a slot address,
  // or show a window at a start address. Items that do nothing (a load into a
  // full buffer, a tick below the period, the unused op code) leave no command.
  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_cmd, q_head;

  stcb_front #(
    .LEVELS   (LEVELS),
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_char_code(in_char_code),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  // A short queue lets the front keep taking items while the back streams a window
  // into a stalled output.
  stcb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (q_pop),
    .head    (q_head)
  );

  // The back end owns the column memory. It runs commands in order: a clear drops
  // all valid bits, a load writes one column per cycle, a window reads one column
  // per cycle, unless out_stall holds it, through the read and output registers.
  stcb_back #(
    .LEVELS   (LEVELS),
    .MAX_CHARS(MAX_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_level  (out_level),
    .out_pattern(out_pattern),
    .out_last   (out_last)
  );

  // The front never pushes into a full queue, and the back never pops an empty one.
  `STCB_NEVER(a_no_push_full, q_push && q_full, "command pushed into a full queue")
  `STCB_NEVER(a_no_pop_empty, q_pop && !q_valid, "command popped from an empty queue")
  // The closing column of a window always sits on the top level.
  `STCB_ASSERT(a_last_level, out_valid && out_last |-> out_level == 3'(LEVELS - 1), "bad last level")

endmodule
